// ===== hdl/pr_pkg.sv =====
// Shared types and constants for the particle resampler.
package pr_pkg;

  localparam int MAX_PARTICLES = 64;
  localparam int IDX_W = $clog2(MAX_PARTICLES);
  localparam int CNT_W = 7;
  localparam int VAL_W = 16;
  localparam int TOT_W = 22;
  localparam int PROD_W = VAL_W + TOT_W;

  // One loaded particle as it travels from the front to the back.
  typedef struct packed {
    logic [VAL_W-1:0] weight;
    logic [VAL_W-1:0] uniform;
    logic [IDX_W-1:0] slot;
    logic             round_end;
    logic [TOT_W-1:0] total;
  } pr_item_t;

  // Handshake pair of the queue ports.
  typedef struct packed {
    logic valid;
    logic ready;
  } pr_hs_t;

  typedef enum logic [3:0] {
    B_LOAD,
    B_RANK,
    B_RANK_WR,
    B_W_INIT,
    B_W_FETCH,
    B_W_CMP,
    B_W_ADV,
    B_W_WAIT
  } pr_bstate_t;

endpackage

// ===== hdl/pr_front.sv =====
// Front end: accepts input beats, assigns slots and tracks the round total.
module pr_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [pr_pkg::VAL_W-1:0]     in_weight,
  input  logic [pr_pkg::VAL_W-1:0]     in_uniform,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [pr_pkg::CNT_W-1:0]     cfg_particle_count,
  output pr_pkg::pr_hs_t               push_hs,
  input  logic                         push_ready,
  output pr_pkg::pr_item_t             push_item
);

  logic [pr_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [pr_pkg::CNT_W-1:0] load_r, load_nxt;
  logic [pr_pkg::TOT_W-1:0] total_r, total_nxt;
  logic [pr_pkg::CNT_W-1:0] eff;
  logic [pr_pkg::IDX_W-1:0] slot;
  logic [pr_pkg::CNT_W-1:0] m;
  logic [pr_pkg::TOT_W-1:0] sum;
  logic                     accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = push_ready;
  assign accept    = in_valid && push_ready;

  // Clamp the configured count into the supported range.
  always_comb begin
    if (count_r == '0) begin
      eff = pr_pkg::CNT_W'(1);
    end else if (count_r > pr_pkg::CNT_W'(pr_pkg::MAX_PARTICLES)) begin
      eff = pr_pkg::CNT_W'(pr_pkg::MAX_PARTICLES);
    end else begin
      eff = count_r;
    end
  end

  // Slot assignment, running sum and round end detection.
  always_comb begin
    if (load_r >= pr_pkg::CNT_W'(pr_pkg::MAX_PARTICLES)) begin
      slot = pr_pkg::IDX_W'(pr_pkg::MAX_PARTICLES - 1);
    end else begin
      slot = load_r[pr_pkg::IDX_W-1:0];
    end
    m   = pr_pkg::CNT_W'(slot) + pr_pkg::CNT_W'(1);
    sum = total_r + pr_pkg::TOT_W'(in_weight);
    push_item.weight    = in_weight;
    push_item.uniform   = in_uniform;
    push_item.slot      = slot;
    push_item.round_end = (m >= eff);
    push_item.total     = sum;
    push_hs.valid = in_valid;
    push_hs.ready = push_ready;
  end

  always_comb begin
    count_nxt = count_r;
    load_nxt  = load_r;
    total_nxt = total_r;
    if (cfg_valid) begin
      count_nxt = cfg_particle_count;
    end
    if (accept) begin
      if (push_item.round_end) begin
        load_nxt  = '0;
        total_nxt = '0;
      end else begin
        load_nxt  = m;
        total_nxt = sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= pr_pkg::CNT_W'(pr_pkg::MAX_PARTICLES);
      load_r  <= '0;
      total_r <= '0;
    end else begin
      count_r <= count_nxt;
      load_r  <= load_nxt;
      total_r <= total_nxt;
    end
  end

endmodule

// ===== hdl/pr_queue.sv =====
// Two-entry queue between the front and the back.
module pr_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  pr_pkg::pr_hs_t   push_hs,
  output logic             push_ready,
  input  pr_pkg::pr_item_t push_item,
  output logic             pop_valid,
  input  logic             pop_ready,
  output pr_pkg::pr_item_t pop_item
);

  pr_pkg::pr_item_t ent_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_item   = ent_r[rp_r];
  assign push       = push_hs.valid && push_hs.ready;
  assign pop        = pop_valid && pop_ready;

  // Pointer and fill bookkeeping.
  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_item;
    end
  end

endmodule

// ===== hdl/pr_back.sv =====
// Back end: stores a round, ranks the uniforms and walks cumulative weights.
module pr_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         pop_valid,
  output logic                         pop_ready,
  input  pr_pkg::pr_item_t             pop_item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [pr_pkg::IDX_W-1:0]     out_parent_index,
  output logic                         out_last_flag
);

  logic [pr_pkg::VAL_W-1:0] wmem [pr_pkg::MAX_PARTICLES];
  logic [pr_pkg::VAL_W-1:0] umem [pr_pkg::MAX_PARTICLES];
  logic [pr_pkg::VAL_W-1:0] smem [pr_pkg::MAX_PARTICLES];
  logic [pr_pkg::VAL_W-1:0] w_rd, ua_rd, ub_rd, s_rd;

  pr_pkg::pr_bstate_t st_r, st_nxt;
  logic [pr_pkg::CNT_W-1:0]  m_r, m_nxt;
  logic [pr_pkg::TOT_W-1:0]  tot_r, tot_nxt;
  logic [pr_pkg::IDX_W-1:0]  i_r, i_nxt;
  logic [pr_pkg::CNT_W-1:0]  j_r, j_nxt;
  logic [pr_pkg::IDX_W-1:0]  jd_r;
  logic                      cv_r;
  logic [pr_pkg::IDX_W-1:0]  rank_r, rank_nxt;
  logic [pr_pkg::IDX_W-1:0]  cnt_r, cnt_nxt;
  logic [pr_pkg::TOT_W-1:0]  cum_r, cum_nxt;
  logic [pr_pkg::PROD_W-1:0] prod_r;
  logic                      ov_r, ov_nxt;
  logic [pr_pkg::IDX_W-1:0]  op_r;
  logic                      ol_r;

  logic                      wr_load, wr_sort, load_prod, emit;
  logic                      inc, adv, free, is_last;
  logic [pr_pkg::IDX_W-1:0]  rank_fin, w_addr;
  logic [pr_pkg::TOT_W-1:0]  samp;

  assign out_valid        = ov_r;
  assign out_parent_index = op_r;
  assign out_last_flag    = ol_r;

  // Datapath conditions shared by the blocks below.
  always_comb begin
    inc      = cv_r && ((ub_rd < ua_rd) || ((ub_rd == ua_rd) && (jd_r < i_r)));
    rank_fin = rank_r + pr_pkg::IDX_W'(inc);
    samp     = prod_r[pr_pkg::PROD_W-1:pr_pkg::VAL_W];
    adv      = !(cum_r > samp)
               && ((pr_pkg::CNT_W'(cnt_r) + pr_pkg::CNT_W'(1)) < m_r);
    free     = !ov_r || out_ready;
    is_last  = (pr_pkg::CNT_W'(i_r) + pr_pkg::CNT_W'(1)) == m_r;
    w_addr   = (st_r == pr_pkg::B_W_INIT) ? '0 : cnt_r + pr_pkg::IDX_W'(1);
  end

  // Next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      pr_pkg::B_LOAD: begin
        if (pop_valid && pop_item.round_end) begin
          st_nxt = pr_pkg::B_RANK;
        end
      end
      pr_pkg::B_RANK: begin
        if (j_r == m_r) begin
          st_nxt = pr_pkg::B_RANK_WR;
        end
      end
      pr_pkg::B_RANK_WR: st_nxt = is_last ? pr_pkg::B_W_INIT : pr_pkg::B_RANK;
      pr_pkg::B_W_INIT:  st_nxt = pr_pkg::B_W_FETCH;
      pr_pkg::B_W_FETCH: st_nxt = pr_pkg::B_W_CMP;
      pr_pkg::B_W_CMP: begin
        if (adv) begin
          st_nxt = pr_pkg::B_W_ADV;
        end else if (free) begin
          st_nxt = is_last ? pr_pkg::B_LOAD : pr_pkg::B_W_WAIT;
        end
      end
      pr_pkg::B_W_ADV:  st_nxt = pr_pkg::B_W_CMP;
      pr_pkg::B_W_WAIT: st_nxt = pr_pkg::B_W_FETCH;
      default:          st_nxt = pr_pkg::B_LOAD;
    endcase
  end

  // Outputs and counters.
  always_comb begin
    pop_ready = 1'b0;
    wr_load   = 1'b0;
    wr_sort   = 1'b0;
    load_prod = 1'b0;
    emit      = 1'b0;
    m_nxt     = m_r;
    tot_nxt   = tot_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    rank_nxt  = rank_r;
    cnt_nxt   = cnt_r;
    cum_nxt   = cum_r;
    ov_nxt    = ov_r && !out_ready;
    case (st_r)
      pr_pkg::B_LOAD: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          wr_load = 1'b1;
          m_nxt   = pr_pkg::CNT_W'(pop_item.slot) + pr_pkg::CNT_W'(1);
          tot_nxt = pop_item.total;
          i_nxt   = '0;
          j_nxt   = '0;
          rank_nxt = '0;
        end
      end
      pr_pkg::B_RANK: begin
        rank_nxt = rank_fin;
        if (j_r != m_r) begin
          j_nxt = j_r + pr_pkg::CNT_W'(1);
        end
      end
      pr_pkg::B_RANK_WR: begin
        wr_sort  = 1'b1;
        rank_nxt = '0;
        j_nxt    = '0;
        i_nxt    = is_last ? '0 : i_r + pr_pkg::IDX_W'(1);
      end
      pr_pkg::B_W_INIT: begin
        cnt_nxt = '0;
      end
      pr_pkg::B_W_FETCH: begin
        load_prod = 1'b1;
        if (i_r == '0) begin
          cum_nxt = pr_pkg::TOT_W'(w_rd);
        end
      end
      pr_pkg::B_W_CMP: begin
        if (adv) begin
          cnt_nxt = cnt_r + pr_pkg::IDX_W'(1);
          cum_nxt = cum_r + pr_pkg::TOT_W'(w_rd);
        end else if (free) begin
          emit   = 1'b1;
          ov_nxt = 1'b1;
          i_nxt  = i_r + pr_pkg::IDX_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= pr_pkg::B_LOAD;
      ov_r <= 1'b0;
      cv_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
      cv_r <= (st_r == pr_pkg::B_RANK) && (j_r != m_r);
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    m_r    <= m_nxt;
    tot_r  <= tot_nxt;
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    jd_r   <= j_r[pr_pkg::IDX_W-1:0];
    rank_r <= rank_nxt;
    cnt_r  <= cnt_nxt;
    cum_r  <= cum_nxt;
    if (load_prod) begin
      prod_r <= pr_pkg::PROD_W'(s_rd) * pr_pkg::PROD_W'(tot_r);
    end
    if (emit) begin
      op_r <= cnt_r;
      ol_r <= is_last;
    end
  end

  // Particle and sorted sample memories with registered reads.
  always_ff @(posedge clk) begin
    if (wr_load) begin
      wmem[pop_item.slot] <= pop_item.weight;
      umem[pop_item.slot] <= pop_item.uniform;
    end
    if (wr_sort) begin
      smem[rank_fin] <= ua_rd;
    end
    w_rd  <= wmem[w_addr];
    ua_rd <= umem[i_r];
    ub_rd <= umem[j_r[pr_pkg::IDX_W-1:0]];
    s_rd  <= smem[i_r];
  end

endmodule

// ===== hdl/particle_resampler.sv =====
// Top level of the particle resampler: front, queue and back.
// Beats load while the queue has room; results follow only after a round's last beat.
// Ranking the uniforms does one compare per cycle on the uniform memory.
// The cumulative walk compares each sample and steps past skipped particles.
// Reset is synchronous and active low; the count returns to 64 and the round restarts.
module particle_resampler (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [pr_pkg::VAL_W-1:0]     in_weight,
  input  logic [pr_pkg::VAL_W-1:0]     in_uniform,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [pr_pkg::IDX_W-1:0]     out_parent_index,
  output logic                         out_last_flag,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [pr_pkg::CNT_W-1:0]     cfg_particle_count
);

  pr_pkg::pr_hs_t   push_hs;
  pr_pkg::pr_item_t push_item, pop_item;
  logic             push_ready, pop_valid, pop_ready;

  pr_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_weight, .in_uniform,
    .cfg_valid, .cfg_ready, .cfg_particle_count,
    .push_hs, .push_ready, .push_item
  );

  pr_queue u_queue (
    .clk, .rst_n, .push_hs, .push_ready, .push_item,
    .pop_valid, .pop_ready, .pop_item
  );

  pr_back u_back (
    .clk, .rst_n, .pop_valid, .pop_ready, .pop_item,
    .out_valid, .out_ready, .out_parent_index, .out_last_flag
  );

endmodule

// ===== hdl/pr_checker.sv =====
// Port-level checks for the particle resampler and their binding.
module pr_checker (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [pr_pkg::IDX_W-1:0] out_parent_index,
  input logic                     out_last_flag,
  input logic                     cfg_ready
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_parent_index)
      && $stable(out_last_flag))
    else $error("result beat changed while stalled");

  // No result right after reset.
  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A valid result beat carries known payload bits.
  a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown({out_parent_index, out_last_flag}))
    else $error("result beat carries unknown bits");

  // The configuration port never stalls.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("configuration port stalled");

endmodule

bind particle_resampler pr_checker u_pr_checker (
  .clk, .rst_n, .out_valid, .out_ready, .out_parent_index, .out_last_flag, .cfg_ready
);
